>>> sv/rrp_pkg.sv
package rrp_pkg;

    localparam int MAX_ARGS   = 1024;
    localparam int MAX_DIGITS = 10;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [10:0] MAX_ARGS_RST     = 11'd1024;
    localparam logic [30:0] MAX_BULK_LEN_RST = 31'd536870912;

    localparam int         CFG_AW       = 3;
    localparam logic       REG_MAX_ARGS = 1'b0;
    localparam logic       REG_MAX_BULK = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_COUNT   = 6'b000010,
        PH_DOLLAR  = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_TRAILER = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LEAD  = 2'd1,
        ERR_DIGIT = 2'd2,
        ERR_RANGE = 2'd3
    } t_err;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  arg_index;
        logic        arg_first;
        logic        arg_last;
        logic        command_done;
        logic [10:0] arg_count;
        t_err        error_code;
    } t_result;

endpackage

>>> sv/rrp_if.sv
interface rrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rrp_res_if;
    logic        valid;
    logic        ready;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [9:0]  arg_index;
    logic        arg_first;
    logic        arg_last;
    logic        command_done;
    logic [10:0] arg_count;
    logic [1:0]  error_code;

    modport source (
        output valid, output data_valid, output data_byte, output arg_index,
        output arg_first, output arg_last, output command_done, output arg_count,
        output error_code, input ready
    );
    modport sink (
        input valid, input data_valid, input data_byte, input arg_index,
        input arg_first, input arg_last, input command_done, input arg_count,
        input error_code, output ready
    );
endinterface

>>> sv/rrp_core.sv
module rrp_core
    import rrp_pkg::*;
#(
    parameter int P_MAX_DIGITS = MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic [10:0] i_max_args,
    input  logic [30:0] i_max_bulk_len,
    output t_result     o_result
);

    localparam int          DW      = $clog2(P_MAX_DIGITS + 1);
    localparam logic [DW-1:0] DIG_MAX = DW'(P_MAX_DIGITS);
    localparam logic [10:0] ARG_CAP = 11'(MAX_ARGS);

    t_phase        r_phase, n_phase;
    logic [31:0]   r_accum, n_accum;
    logic [10:0]   r_total, n_total;
    logic [10:0]   r_left, n_left;
    logic [9:0]    r_cur, n_cur;
    logic [30:0]   r_bytes, n_bytes;
    logic [1:0]    r_trailer, n_trailer;
    logic [DW-1:0] r_digits, n_digits;

    logic [35:0] prod;
    logic [31:0] acc_sat;
    logic [10:0] arg_lim;
    logic        is_digit;
    t_err        err;
    t_result     res;

    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign prod     = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1)
                    + {28'b0, i_rx_byte - CH_ZERO};
    assign acc_sat  = (|prod[35:32]) ? '1 : prod[31:0];
    assign arg_lim  = (i_max_args > ARG_CAP) ? ARG_CAP : i_max_args;

    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_total   = r_total;
        n_left    = r_left;
        n_cur     = r_cur;
        n_bytes   = r_bytes;
        n_trailer = r_trailer;
        n_digits  = r_digits;
        err       = ERR_NONE;
        res       = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == CH_STAR) begin
                    n_phase  = PH_COUNT;
                    n_accum  = '0;
                    n_digits = '0;
                end else begin
                    err = ERR_LEAD;
                end
            end
            PH_DOLLAR: begin
                if (i_rx_byte == CH_DOLLAR) begin
                    n_phase  = PH_LEN;
                    n_accum  = '0;
                    n_digits = '0;
                end else begin
                    err = ERR_LEAD;
                end
            end
            PH_COUNT, PH_LEN: begin
                if (i_rx_byte == CH_CR) begin
                    n_phase = r_phase;
                end else if (i_rx_byte == CH_LF) begin
                    if (r_phase == PH_COUNT) begin
                        if (r_accum == '0 || r_accum > {21'b0, arg_lim}) begin
                            err = ERR_RANGE;
                        end else begin
                            n_total = r_accum[10:0];
                            n_left  = r_accum[10:0];
                            n_cur   = '0;
                            n_phase = PH_DOLLAR;
                        end
                    end else begin
                        if (r_accum == '0 || r_accum > {1'b0, i_max_bulk_len}) begin
                            err = ERR_RANGE;
                        end else begin
                            n_bytes = r_accum[30:0];
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end else if (is_digit) begin
                    if (r_digits >= DIG_MAX) begin
                        err = ERR_RANGE;
                    end else begin
                        n_accum  = acc_sat;
                        n_digits = r_digits + 1'b1;
                    end
                end else begin
                    err = ERR_DIGIT;
                end
            end
            PH_PAYLOAD: begin
                res.data_valid = 1'b1;
                res.data_byte  = i_rx_byte;
                res.arg_index  = r_cur;
                res.arg_first  = ({1'b0, r_bytes} == r_accum);
                res.arg_last   = (r_bytes <= 31'd1);
                if (r_bytes <= 31'd1) begin
                    n_bytes   = '0;
                    n_trailer = 2'd2;
                    n_phase   = PH_TRAILER;
                end else begin
                    n_bytes = r_bytes - 1'b1;
                end
            end
            PH_TRAILER: begin
                if (r_trailer > 2'd1) begin
                    n_trailer = r_trailer - 1'b1;
                end else begin
                    n_trailer = '0;
                    n_cur     = r_cur + 1'b1;
                    if (r_left <= 11'd1) begin
                        res.command_done = 1'b1;
                        res.arg_count    = r_total;
                        n_phase   = PH_IDLE;
                        n_accum   = '0;
                        n_total   = '0;
                        n_left    = '0;
                        n_cur     = '0;
                        n_bytes   = '0;
                        n_digits  = '0;
                    end else begin
                        n_left  = r_left - 1'b1;
                        n_phase = PH_DOLLAR;
                    end
                end
            end
            default: begin
                n_phase   = PH_IDLE;
                n_accum   = '0;
                n_total   = '0;
                n_left    = '0;
                n_cur     = '0;
                n_bytes   = '0;
                n_trailer = '0;
                n_digits  = '0;
            end
        endcase
        if (err != ERR_NONE) begin
            res            = '0;
            res.error_code = err;
            n_phase   = PH_IDLE;
            n_accum   = '0;
            n_total   = '0;
            n_left    = '0;
            n_cur     = '0;
            n_bytes   = '0;
            n_trailer = '0;
            n_digits  = '0;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_accum   <= '0;
            r_total   <= '0;
            r_left    <= '0;
            r_cur     <= '0;
            r_bytes   <= '0;
            r_trailer <= '0;
            r_digits  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_accum   <= n_accum;
            r_total   <= n_total;
            r_left    <= n_left;
            r_cur     <= n_cur;
            r_bytes   <= n_bytes;
            r_trailer <= n_trailer;
            r_digits  <= n_digits;
        end
    end

endmodule

>>> sv/resp_request_parser.sv
// multibulk request parser, one request byte per item, one result per item
// the result is valid on the output register in the cycle after input accept
// throughput: 1 item per cycle, input stays ready while the output register
// is empty or being drained in the same cycle
// reset (synchronous, active low): parser idle expecting '*', output empty,
// max_args = 1024, max_bulk_len = 2^29
module resp_request_parser
    import rrp_pkg::*;
#(
    parameter int P_MAX_DIGITS = MAX_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rrp_byte_if.sink          i_rx,
    rrp_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [10:0] r_max_args;
    logic [30:0] r_max_bulk_len;
    logic        r_out_valid;
    t_result     r_res;
    t_result     core_res;
    logic        in_ready;
    logic        accept;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX_BULK) ? {1'b0, r_max_bulk_len}
                                               : {21'b0, r_max_args};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args     <= MAX_ARGS_RST;
            r_max_bulk_len <= MAX_BULK_LEN_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_ARGS) begin
                r_max_args <= pwdata[10:0];
            end else begin
                r_max_bulk_len <= pwdata[30:0];
            end
        end
    end

    assign in_ready   = !r_out_valid || o_res.ready;
    assign i_rx.ready = in_ready;
    assign accept     = i_rx.valid && in_ready;

    rrp_core #(
        .P_MAX_DIGITS (P_MAX_DIGITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx.rx_byte),
        .i_max_args     (r_max_args),
        .i_max_bulk_len (r_max_bulk_len),
        .o_result       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= core_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.data_valid   = r_res.data_valid;
    assign o_res.data_byte    = r_res.data_byte;
    assign o_res.arg_index    = r_res.arg_index;
    assign o_res.arg_first    = r_res.arg_first;
    assign o_res.arg_last     = r_res.arg_last;
    assign o_res.command_done = r_res.command_done;
    assign o_res.arg_count    = r_res.arg_count;
    assign o_res.error_code   = r_res.error_code;

endmodule
